// File: rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the LRU frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int NumFramesDef = 64;
  localparam int FrameNumW    = 6;
  localparam int CountW       = 7;

  // request codes; code 3 is unused and treated as a no-op
  typedef enum logic [1:0] {
    REQ_VICTIM = 2'd0,
    REQ_PIN    = 2'd1,
    REQ_UNPIN  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_UNLINK2
  } state_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [FrameNumW-1:0] frame_num;
  } req_t;

  typedef struct packed {
    logic                 victim_found;
    logic [FrameNumW-1:0] victim_frame;
    logic [CountW-1:0]    tracked_count;
  } rsp_t;

  // result hand-off from the controller to the output register
  typedef struct packed {
    logic valid;
    rsp_t beat;
  } res_load_t;

endpackage

// File: rtl/lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_core
// LRU replacer over buffer frames, list links kept in two memories.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat. Unpin, pin, a victim
// taken at either end of the list, and unused or out-of-range requests go
// through accept, memory read and execute; a pin that removes a frame from
// the middle of the list adds a second unlink step, since the older-link
// memory has one write port and must rewrite the next neighbor and then
// clear the frame's own tracked flag. The next request is taken while the
// previous result still sits in the output register; the execute step waits
// only if that register is still full. After reset the block runs a clearing
// pass over every frame's tracked flag, with in_ready_o low.
module lru_frame_replacer_core #(
  parameter int NUM_FRAMES = lfr_pkg::NumFramesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lfr_pkg::rsp_t out_rsp_o
);

  localparam int FrameW = $clog2(NUM_FRAMES);

  // link memory ports
  logic [FrameW-1:0] rd_addr;
  logic              nw_we;
  logic [FrameW-1:0] nw_waddr;
  logic [FrameW-1:0] nw_wdata;
  logic [FrameW-1:0] nw_rdata;
  logic              ol_we;
  logic [FrameW-1:0] ol_waddr;
  logic [FrameW:0]   ol_wdata;
  logic [FrameW:0]   ol_rdata;

  lfr_pkg::res_load_t res;
  logic               slot_free;

  // output register
  logic          out_valid_q;
  lfr_pkg::rsp_t out_rsp_q;

  // slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  lfr_ctrl #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .nw_we_o     (nw_we),
    .nw_waddr_o  (nw_waddr),
    .nw_wdata_o  (nw_wdata),
    .nw_rdata_i  (nw_rdata),
    .ol_we_o     (ol_we),
    .ol_waddr_o  (ol_waddr),
    .ol_wdata_o  (ol_wdata),
    .ol_rdata_i  (ol_rdata)
  );

  // newer-link store: next more recent frame
  lfr_ram #(
    .Depth (NUM_FRAMES),
    .Width (FrameW)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (nw_we),
    .waddr_i (nw_waddr),
    .wdata_i (nw_wdata),
    .raddr_i (rd_addr),
    .rdata_o (nw_rdata)
  );

  // older-link store, tracked flag in the top bit
  lfr_ram #(
    .Depth (NUM_FRAMES),
    .Width (FrameW + 1)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (ol_we),
    .waddr_i (ol_waddr),
    .wdata_i (ol_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ol_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_rsp_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: rtl/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module lfr_ram #(
  parameter int Depth = lfr_pkg::NumFramesDef,
  parameter int Width = lfr_pkg::FrameNumW,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// lfr_ctrl
// Request sequencer: reads the link stores, updates the list ends and the
// count, and issues the link write-backs.
// ----------------------------------------------------------------------------
module lfr_ctrl #(
  parameter int NUM_FRAMES = lfr_pkg::NumFramesDef,
  localparam int FrameW = $clog2(NUM_FRAMES),
  localparam int CntW   = $clog2(NUM_FRAMES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lfr_pkg::req_t      in_req_i,
  output logic               in_ready_o,
  input  logic               slot_free_i,
  output lfr_pkg::res_load_t res_o,
  output logic [FrameW-1:0]  rd_addr_o,
  output logic               nw_we_o,
  output logic [FrameW-1:0]  nw_waddr_o,
  output logic [FrameW-1:0]  nw_wdata_o,
  input  logic [FrameW-1:0]  nw_rdata_i,
  output logic               ol_we_o,
  output logic [FrameW-1:0]  ol_waddr_o,
  output logic [FrameW:0]    ol_wdata_o,
  input  logic [FrameW:0]    ol_rdata_i
);

  localparam int FnW = lfr_pkg::FrameNumW;
  localparam int OcW = lfr_pkg::CountW;

  lfr_pkg::state_e state_q, state_d;

  logic [1:0]        req_q;
  logic [FrameW-1:0] frm_q;
  logic              inrange_q;
  logic [FrameW-1:0] newest_q, newest_d;
  logic [FrameW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FrameW-1:0] clr_q;

  logic              accept;
  logic              tracked;
  logic [FrameW-1:0] link_new;
  logic [FrameW-1:0] link_old;
  logic              do_unlink;
  logic              do_push;
  logic              is_mid;
  logic              clr_last;

  assign accept    = (state_q == lfr_pkg::ST_IDLE) && in_valid_i;
  assign clr_last  = (clr_q == FrameW'(NUM_FRAMES - 1));
  assign rd_addr_o = frm_q;

  // decode of the entry read for this request
  always_comb begin
    tracked   = ol_rdata_i[FrameW];
    link_new  = nw_rdata_i;
    link_old  = ol_rdata_i[FrameW-1:0];
    do_unlink = ((req_q == lfr_pkg::REQ_VICTIM) && (cnt_q != '0)) ||
                ((req_q == lfr_pkg::REQ_PIN) && inrange_q && tracked);
    do_push   = (req_q == lfr_pkg::REQ_UNPIN) && inrange_q && !tracked &&
                (cnt_q < CntW'(NUM_FRAMES));
    is_mid    = do_unlink && (cnt_q > CntW'(1)) &&
                (frm_q != oldest_q) && (frm_q != newest_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfr_pkg::ST_CLEAR: begin
        if (clr_last) state_d = lfr_pkg::ST_IDLE;
      end
      lfr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lfr_pkg::ST_READ;
      end
      lfr_pkg::ST_READ: begin
        state_d = lfr_pkg::ST_EXEC;
      end
      lfr_pkg::ST_EXEC: begin
        if (slot_free_i) state_d = is_mid ? lfr_pkg::ST_UNLINK2 : lfr_pkg::ST_IDLE;
      end
      lfr_pkg::ST_UNLINK2: begin
        state_d = lfr_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfr_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs, write-backs and list end updates
  always_comb begin
    in_ready_o = (state_q == lfr_pkg::ST_IDLE);
    res_o      = '0;
    nw_we_o    = 1'b0;
    nw_waddr_o = frm_q;
    nw_wdata_o = link_new;
    ol_we_o    = 1'b0;
    ol_waddr_o = frm_q;
    ol_wdata_o = '0;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    cnt_d      = cnt_q;
    case (state_q)
      lfr_pkg::ST_CLEAR: begin
        ol_we_o    = 1'b1;
        ol_waddr_o = clr_q;
      end
      lfr_pkg::ST_EXEC: begin
        if (slot_free_i) begin
          if (do_unlink) begin
            cnt_d = cnt_q - CntW'(1);
            if (cnt_q <= CntW'(1)) begin
              newest_d = '0;
              oldest_d = '0;
              ol_we_o  = 1'b1;
            end else if (frm_q == oldest_q) begin
              oldest_d = link_new;
              ol_we_o  = 1'b1;
            end else if (frm_q == newest_q) begin
              newest_d = link_old;
              ol_we_o  = 1'b1;
            end else begin
              // splice neighbors; the flag clear follows next cycle
              nw_we_o    = 1'b1;
              nw_waddr_o = link_old;
              nw_wdata_o = link_new;
              ol_we_o    = 1'b1;
              ol_waddr_o = link_new;
              ol_wdata_o = {1'b1, link_old};
            end
          end else if (do_push) begin
            cnt_d      = cnt_q + CntW'(1);
            newest_d   = frm_q;
            ol_we_o    = 1'b1;
            ol_wdata_o = {1'b1, newest_q};
            if (cnt_q == '0) begin
              oldest_d = frm_q;
            end else begin
              nw_we_o    = 1'b1;
              nw_waddr_o = newest_q;
              nw_wdata_o = frm_q;
            end
          end
          res_o.valid              = 1'b1;
          res_o.beat.victim_found  = (req_q == lfr_pkg::REQ_VICTIM) && do_unlink;
          res_o.beat.victim_frame  = res_o.beat.victim_found ? FnW'(frm_q) : '0;
          res_o.beat.tracked_count = OcW'(cnt_d);
        end
      end
      lfr_pkg::ST_UNLINK2: begin
        ol_we_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lfr_pkg::ST_CLEAR;
      clr_q    <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      if (state_q == lfr_pkg::ST_CLEAR) begin
        clr_q <= clr_q + FrameW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= in_req_i.req_type;
      inrange_q <= (32'(in_req_i.frame_num) < 32'(NUM_FRAMES));
      frm_q     <= (in_req_i.req_type == lfr_pkg::REQ_VICTIM) ? oldest_q
                                                               : FrameW'(in_req_i.frame_num);
    end
  end

  // list bookkeeping checks
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NUM_FRAMES))
    else $error("tracked count above frame count");

  a_cnt_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |=> $stable(cnt_q) && $stable(newest_q) && $stable(oldest_q))
    else $error("list state changed without a result");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (newest_q == '0) && (oldest_q == '0))
    else $error("empty list with nonzero ends");

  a_single_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1)) |-> (newest_q == oldest_q))
    else $error("single entry list with distinct ends");

  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> slot_free_i && (state_q == lfr_pkg::ST_EXEC))
    else $error("result loaded into a busy output slot");

endmodule
